@@ src/mbrc_pkg.sv @@
package mbrc_pkg;

  // Protocol limits
  localparam logic [7:0]  MAX_UNIT  = 8'd247;
  localparam logic [7:0]  MAX_WORDS = 8'd125;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [8:0]  POS_MAX   = 9'd511;

  // Accepted function codes
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT   = 8'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_UNIT_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_FUNCTION_CODE = 2'd1;
  localparam logic [1:0] REG_WORD_COUNT    = 2'd2;

  // Result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_CFG   = 3'd1,
    ST_LENGTH    = 3'd2,
    ST_UNIT      = 3'd3,
    ST_FUNCTION  = 3'd4,
    ST_BYTE_CNT  = 3'd5,
    ST_CRC       = 3'd6
  } status_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [15:0] data_word;
    logic [6:0]  word_index;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic [7:0] unit_address;
    logic [7:0] function_code;
    logic [7:0] word_count;
  } cfg_t;

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ src/modbus_rtu_response_checker.sv @@
// Modbus RTU read-response checker (function 3 or 4). Frame bytes enter one per
// transfer on the in_ stream, in_tlast on the last byte. Each complete register
// word (high byte first) leaves as a tentative data result (out_tuser = 0) as
// soon as its low byte arrives; the last byte yields a single verdict
// (out_tuser = 1) with status 0 ok, 1 bad config, 2 length, 3 unit, 4 function,
// 5 byte count, 6 CRC. The block takes one byte per clock unless out_tready stalls;
// the CRC-16 byte update between the input and result registers sets the clock limit.
// Registers are to be written over cfg_ only while idle, a rule the block does not enforce.
module modbus_rtu_response_checker (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // frame_end
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] data_word, [22:16] word_index, [25:23] status
  output logic        out_tuser,  // result_kind
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import mbrc_pkg::*;

  cfg_t        cfg_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        out_valid_r;
  logic        out_kind_r;
  logic [15:0] out_word_r;
  logic [6:0]  out_idx_r;
  status_t     out_status_r;
  logic        adv;
  logic        fire;
  result_t     res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_address  <= 8'd1;
      cfg_r.function_code <= FC_READ_HOLDING;
      cfg_r.word_count    <= 8'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_UNIT_ADDRESS:  cfg_r.unit_address  <= cfg_data;
        REG_FUNCTION_CODE: cfg_r.function_code <= cfg_data;
        REG_WORD_COUNT:    cfg_r.word_count    <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Pipeline control
  assign adv       = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  mbrc_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .fire      (fire),
    .rx_byte   (s1_byte_r),
    .frame_end (s1_last_r),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_kind_r   <= res.kind;
      out_word_r   <= res.data_word;
      out_idx_r    <= res.word_index;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'd0, out_status_r, out_idx_r, out_word_r};

endmodule

@@ src/mbrc_frame.sv @@
// Frame tracker: header compare, CRC over delayed bytes, word assembly, verdict
module mbrc_frame (
  input  logic            clk,
  input  logic            rst_n,
  input  mbrc_pkg::cfg_t  cfg,
  input  logic            fire,
  input  logic [7:0]      rx_byte,
  input  logic            frame_end,
  output mbrc_pkg::result_t res
);
  import mbrc_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  dly0_r, dly0_nxt;
  logic [7:0]  dly1_r, dly1_nxt;
  logic [7:0]  hi_r, hi_nxt;
  status_t     fault_r, fault_nxt;

  logic        cfg_ok;
  logic [8:0]  exp_bytes;
  logic [9:0]  exp_len;
  logic [9:0]  length;
  logic [8:0]  off;
  logic [15:0] crc_upd;

  // Register validity
  assign cfg_ok = (cfg.unit_address != 8'd0) && (cfg.unit_address <= MAX_UNIT) &&
                  ((cfg.function_code == FC_READ_HOLDING) ||
                   (cfg.function_code == FC_READ_INPUT)) &&
                  (cfg.word_count != 8'd0) && (cfg.word_count <= MAX_WORDS);

  assign exp_bytes = {cfg.word_count, 1'b0};
  assign exp_len   = {1'b0, exp_bytes} + 10'd5;
  assign length    = {1'b0, pos_r} + 10'd1;
  assign off       = pos_r - 9'd3;
  assign crc_upd   = crc16_byte(crc_r, dly1_r);

  always_comb begin
    res       = '0;
    res.status = ST_OK;
    crc_nxt   = crc_r;
    pos_nxt   = pos_r;
    dly0_nxt  = dly0_r;
    dly1_nxt  = dly1_r;
    hi_nxt    = hi_r;
    fault_nxt = fault_r;

    // First header fault in byte order
    if (fault_r == ST_OK) begin
      if (pos_r == 9'd0 && rx_byte != cfg.unit_address) begin
        fault_nxt = ST_UNIT;
      end else if (pos_r == 9'd1 && rx_byte != cfg.function_code) begin
        fault_nxt = ST_FUNCTION;
      end else if (pos_r == 9'd2 && {1'b0, rx_byte} != exp_bytes) begin
        fault_nxt = ST_BYTE_CNT;
      end
    end

    // CRC runs two bytes behind so the trailer is left out
    if (pos_r >= 9'd2) begin
      crc_nxt = crc_upd;
    end

    if (frame_end) begin
      res.valid = 1'b1;
      res.kind  = KIND_VERDICT;
      if (!cfg_ok) begin
        res.status = ST_BAD_CFG;
      end else if (length != exp_len) begin
        res.status = ST_LENGTH;
      end else if (fault_nxt != ST_OK) begin
        res.status = fault_nxt;
      end else if (dly0_r != crc_nxt[7:0] || rx_byte != crc_nxt[15:8]) begin
        res.status = ST_CRC;
      end
      // Back to idle frame state
      crc_nxt   = CRC_INIT;
      pos_nxt   = '0;
      dly0_nxt  = '0;
      dly1_nxt  = '0;
      hi_nxt    = '0;
      fault_nxt = ST_OK;
    end else begin
      // Data area: high byte held, word emitted on the low byte
      if (cfg_ok && pos_r >= 9'd3) begin
        if (!off[0]) begin
          hi_nxt = rx_byte;
        end else if (off[8:1] < cfg.word_count) begin
          res.valid      = 1'b1;
          res.kind       = KIND_DATA;
          res.data_word  = {hi_r, rx_byte};
          res.word_index = off[7:1];
        end
      end
      dly1_nxt = dly0_r;
      dly0_nxt = rx_byte;
      if (pos_r < POS_MAX) begin
        pos_nxt = pos_r + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      pos_r   <= '0;
      dly0_r  <= '0;
      dly1_r  <= '0;
      hi_r    <= '0;
      fault_r <= ST_OK;
    end else if (fire) begin
      crc_r   <= crc_nxt;
      pos_r   <= pos_nxt;
      dly0_r  <= dly0_nxt;
      dly1_r  <= dly1_nxt;
      hi_r    <= hi_nxt;
      fault_r <= fault_nxt;
    end
  end

endmodule
